// ===== rtl/json_token_syntax_checker_macros.svh =====
// Assertion macros used by the checker file jtsc_checker.sv
`ifndef JSON_TOKEN_SYNTAX_CHECKER_MACROS_SVH
`define JSON_TOKEN_SYNTAX_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define JTSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define JTSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jtsc_pkg.sv =====
// Types and constants of the JSON token syntax checker
`timescale 1ns / 1ps
package jtsc_pkg;

    localparam int TOKEN_W   = 4;
    localparam int VERDICT_W = 2;
    localparam int DEPTH_W   = 7;
    localparam int LIMIT_W   = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [TOKEN_W-1:0] TK_LBRACE   = 4'd0;
    localparam logic [TOKEN_W-1:0] TK_RBRACE   = 4'd1;
    localparam logic [TOKEN_W-1:0] TK_LBRACKET = 4'd2;
    localparam logic [TOKEN_W-1:0] TK_RBRACKET = 4'd3;
    localparam logic [TOKEN_W-1:0] TK_COLON    = 4'd4;
    localparam logic [TOKEN_W-1:0] TK_COMMA    = 4'd5;
    localparam logic [TOKEN_W-1:0] TK_STRING   = 4'd6;
    localparam logic [TOKEN_W-1:0] TK_NULL     = 4'd12;
    localparam logic [TOKEN_W-1:0] TK_INVALID  = 4'd13;

    localparam logic [VERDICT_W-1:0] VERDICT_INCOMPLETE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_COMPLETE   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_ERROR      = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_DEEP   = 2'd3;

    typedef enum logic [3:0] {
        ST_START    = 4'd0,
        ST_OBJ_OPEN = 4'd1,
        ST_KEY      = 4'd2,
        ST_COLON    = 4'd3,
        ST_VALUE    = 4'd4,
        ST_ARR_OPEN = 4'd5,
        ST_COMMA    = 4'd6,
        ST_FINISHED = 4'd7,
        ST_ERROR    = 4'd8,
        ST_DEEP     = 4'd9
    } parse_state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP
    } stack_act_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [DEPTH_W-1:0]   nesting_depth;
    } result_t;

endpackage

// ===== rtl/jtsc_ifs.sv =====
// Handshake channel interfaces: token requests, results, configuration writes
`timescale 1ns / 1ps
interface jtsc_token_if;
    import jtsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [TOKEN_W-1:0] token_kind;
    logic               document_start;
    modport source (output valid, output token_kind, output document_start, input ready);
    modport sink (input valid, input token_kind, input document_start, output ready);
endinterface

interface jtsc_result_if;
    import jtsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [DEPTH_W-1:0]   nesting_depth;
    modport source (output valid, output verdict, output nesting_depth, input ready);
    modport sink (input valid, input verdict, input nesting_depth, output ready);
endinterface

interface jtsc_cfg_if;
    import jtsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/jtsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module jtsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/json_token_syntax_checker.sv =====
// Throughput: one token request per cycle while no result sits in the skid entry, one
// result per token. The parse state, open-container count and the kind of the innermost
// container sit in registers; containers below the innermost one live in a RAM whose
// registered read port always prefetches the entry just below the top, with a bypass for
// the entry written by the push of the previous cycle, so a close can follow any token
// directly. A result register plus one skid entry let a new token be taken while a result
// waits. The stack RAM is never cleared: entries are only read after being pushed.
`timescale 1ns / 1ps
module json_token_syntax_checker #(
    parameter int MAX_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    jtsc_token_if.sink         tok,
    jtsc_result_if.source      res,
    jtsc_cfg_if.sink           cfg
);
    import jtsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int MEM_D = (MAX_DEPTH > 1) ? (MAX_DEPTH - 1) : 1;
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam logic [LW-1:0] MAX_EXT = LW'(MAX_DEPTH);

    parse_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               top_obj_reg, top_obj_next;
    logic               bypass_reg;
    logic               bypass_data_reg;
    logic [LIMIT_W-1:0] limit_reg;

    result_t            out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;

    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic               ram_rdata;
    logic               below_obj;

    parse_state_t       s_cur, s_upd;
    logic [CNT_W-1:0]   c_cur, c_upd, c_minus2;
    logic [LW-1:0]      c_ext, lim_ext, cfg_ext;
    stack_act_t         act;
    logic               value_slot, close_req;
    parse_state_t       scalar_next;
    logic               is_open, is_obj, is_scalar;
    logic [CNT_W+DEPTH_W-1:0] depth_wide;
    result_t            result;

    assign accept    = tok.valid && tok.ready;
    assign tok.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;

    // entry just below the top: from RAM, or from the push of last cycle
    assign below_obj = bypass_reg ? bypass_data_reg : ram_rdata;

    assign cfg_ext = LW'(limit_reg);
    assign lim_ext = (cfg_ext < MAX_EXT) ? cfg_ext : MAX_EXT;

    assign is_open   = (tok.token_kind == TK_LBRACE) || (tok.token_kind == TK_LBRACKET);
    assign is_obj    = (tok.token_kind == TK_LBRACE);
    assign is_scalar = tok.token_kind inside {[TK_STRING:TK_NULL]};

    always_comb
    begin
        s_cur       = tok.document_start ? ST_START : state_reg;
        c_cur       = tok.document_start ? '0 : count_reg;
        c_ext       = LW'(c_cur);
        s_upd       = s_cur;
        act         = ACT_NONE;
        value_slot  = 1'b0;
        close_req   = 1'b0;
        scalar_next = ST_VALUE;

        if (s_cur == ST_ERROR || s_cur == ST_DEEP)
        begin
            s_upd = s_cur;
        end
        else if (tok.token_kind >= TK_INVALID || s_cur == ST_FINISHED)
        begin
            s_upd = ST_ERROR;
        end
        else if ((s_cur == ST_VALUE || s_cur == ST_COMMA) && c_cur == '0)
        begin
            s_upd = ST_ERROR;
        end
        else
        begin
            case (s_cur)
                ST_START:
                begin
                    value_slot  = 1'b1;
                    scalar_next = ST_FINISHED;
                end
                ST_OBJ_OPEN:
                begin
                    if (tok.token_kind == TK_RBRACE)
                        close_req = 1'b1;
                    else
                        s_upd = (tok.token_kind == TK_STRING) ? ST_KEY : ST_ERROR;
                end
                ST_KEY:
                begin
                    s_upd = (tok.token_kind == TK_COLON) ? ST_COLON : ST_ERROR;
                end
                ST_COLON:
                begin
                    value_slot = 1'b1;
                end
                ST_VALUE:
                begin
                    if (tok.token_kind == TK_COMMA)
                        s_upd = ST_COMMA;
                    else if ((top_obj_reg && tok.token_kind == TK_RBRACE) ||
                             (!top_obj_reg && tok.token_kind == TK_RBRACKET))
                        close_req = 1'b1;
                    else
                        s_upd = ST_ERROR;
                end
                ST_ARR_OPEN:
                begin
                    if (tok.token_kind == TK_RBRACKET)
                        close_req = 1'b1;
                    else
                        value_slot = 1'b1;
                end
                ST_COMMA:
                begin
                    if (top_obj_reg)
                        s_upd = (tok.token_kind == TK_STRING) ? ST_KEY : ST_ERROR;
                    else
                        value_slot = 1'b1;
                end
                default:
                begin
                    s_upd = ST_ERROR;
                end
            endcase
        end

        if (value_slot)
        begin
            if (is_open)
            begin
                if (c_ext >= lim_ext)
                begin
                    s_upd = ST_DEEP;
                end
                else
                begin
                    act   = ACT_PUSH;
                    s_upd = is_obj ? ST_OBJ_OPEN : ST_ARR_OPEN;
                end
            end
            else if (is_scalar)
            begin
                s_upd = scalar_next;
            end
            else
            begin
                s_upd = ST_ERROR;
            end
        end

        if (close_req)
        begin
            if (c_cur == '0)
            begin
                s_upd = ST_ERROR;
            end
            else
            begin
                act   = ACT_POP;
                s_upd = (c_cur == CNT_W'(1)) ? ST_FINISHED : ST_VALUE;
            end
        end

        case (act)
            ACT_PUSH: c_upd = c_cur + CNT_W'(1);
            ACT_POP:  c_upd = c_cur - CNT_W'(1);
            default:  c_upd = c_cur;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_obj_next = top_obj_reg;
        ram_we       = 1'b0;
        ram_waddr    = AW'(c_cur - CNT_W'(1));
        if (accept)
        begin
            state_next = s_upd;
            count_next = c_upd;
            case (act)
                ACT_PUSH:
                begin
                    top_obj_next = is_obj;
                    // old top moves into the RAM
                    ram_we       = (c_cur != '0);
                end
                ACT_POP:
                begin
                    top_obj_next = below_obj;
                end
                default:
                begin
                    top_obj_next = top_obj_reg;
                end
            endcase
        end
        c_minus2  = count_next - CNT_W'(2);
        ram_raddr = c_minus2[AW-1:0];
    end

    assign depth_wide           = {{DEPTH_W{1'b0}}, c_upd};
    assign result.nesting_depth = depth_wide[DEPTH_W-1:0];

    always_comb
    begin
        case (s_upd)
            ST_FINISHED: result.verdict = VERDICT_COMPLETE;
            ST_ERROR:    result.verdict = VERDICT_ERROR;
            ST_DEEP:     result.verdict = VERDICT_TOO_DEEP;
            default:     result.verdict = VERDICT_INCOMPLETE;
        endcase
    end

    jtsc_ram #(
        .WIDTH (1),
        .DEPTH (MEM_D),
        .AW    (AW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_obj_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            bypass_reg <= ram_we;
            if (cfg.valid && cfg.ready)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_obj_reg     <= top_obj_next;
        bypass_data_reg <= top_obj_reg;
    end

    // result register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (out_valid_reg && !res.ready)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (res.ready && out_valid_reg)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (out_valid_reg && !res.ready)
                skid_reg <= result;
            else
                out_reg <= result;
        end
        else if (res.ready && out_valid_reg && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.verdict       = out_reg.verdict;
    assign res.nesting_depth = out_reg.nesting_depth;

endmodule

// ===== rtl/jtsc_checker.sv =====
// Port-level assertions for the JSON token syntax checker and their bind
`timescale 1ns / 1ps
`include "json_token_syntax_checker_macros.svh"
module jtsc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      tok_valid,
    input logic                      tok_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [jtsc_pkg::VERDICT_W-1:0] res_verdict,
    input logic [jtsc_pkg::DEPTH_W-1:0]   res_nesting_depth
);
    import jtsc_pkg::*;

    `JTSC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_verdict) && $stable(res_nesting_depth), "stalled result changed")
    `JTSC_ASSERT_SAME(a_complete_empty, res_valid && res_verdict == VERDICT_COMPLETE, res_nesting_depth == '0, "complete verdict with open containers")
    `JTSC_ASSERT_NEXT(a_skid_fills, tok_valid && tok_ready && res_valid && !res_ready, !tok_ready, "token taken with no room for its result")
    `JTSC_ASSERT_SAME(a_stall_has_result, !tok_ready, res_valid, "token request stalled with no pending result")

endmodule

bind json_token_syntax_checker jtsc_checker u_jtsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (tok.valid),
    .tok_ready         (tok.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_verdict       (res.verdict),
    .res_nesting_depth (res.nesting_depth)
);

// ===== dv/tb_json_token_syntax_checker.sv =====
// Self-checking testbench for the JSON token syntax checker: grammar-driven token requests
`timescale 1ns / 1ps
module tb_json_token_syntax_checker;
    import jtsc_pkg::*;

    localparam int STACK_SLOTS = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 170;
    localparam int NUM_PHASES  = 5;

    // scalar and spare kinds without a package name
    localparam logic [TOKEN_W-1:0] TK_INT   = 4'd7;
    localparam logic [TOKEN_W-1:0] TK_FLOAT = 4'd8;
    localparam logic [TOKEN_W-1:0] TK_SCI   = 4'd9;
    localparam logic [TOKEN_W-1:0] TK_TRUE  = 4'd10;
    localparam logic [TOKEN_W-1:0] TK_FALSE = 4'd11;
    localparam logic [TOKEN_W-1:0] TK_RSVD0 = 4'd14;
    localparam logic [TOKEN_W-1:0] TK_RSVD1 = 4'd15;

    // Shadow pushdown parser plus the queue of verdicts still owed by the block
    class verdict_tracker;
        parse_state_t       state;
        bit                 obj_stack[STACK_SLOTS];
        int                 open_count;
        logic [LIMIT_W-1:0] limit;
        result_t            pending_verdicts[$];
        int                 mismatches;
        int                 checked;
        int                 verdict_hits[4];
        int                 deepest;

        function new();
            state      = ST_START;
            open_count = 0;
            limit      = LIMIT_RESET;
            mismatches = 0;
            checked    = 0;
            deepest    = 0;
            foreach (verdict_hits[i])
                verdict_hits[i] = 0;
        endfunction

        function int depth_cap();
            return (limit > STACK_SLOTS) ? STACK_SLOTS : int'(limit);
        endfunction

        function void open_box(bit is_obj);
            if (open_count >= depth_cap())
            begin
                state = ST_DEEP;
                return;
            end
            obj_stack[open_count] = is_obj;
            open_count++;
            state = is_obj ? ST_OBJ_OPEN : ST_ARR_OPEN;
        endfunction

        function void close_box();
            if (open_count == 0)
            begin
                state = ST_ERROR;
                return;
            end
            open_count--;
            state = (open_count == 0) ? ST_FINISHED : ST_VALUE;
        endfunction

        function void take_value(logic [TOKEN_W-1:0] kind, parse_state_t scalar_next);
            if (kind == TK_LBRACE)
                open_box(1'b1);
            else if (kind == TK_LBRACKET)
                open_box(1'b0);
            else if (kind >= TK_STRING && kind <= TK_NULL)
                state = scalar_next;
            else
                state = ST_ERROR;
        endfunction

        function void advance(logic [TOKEN_W-1:0] kind);
            bit top_obj;
            top_obj = 1'b0;
            if (state == ST_ERROR || state == ST_DEEP)
                return;
            if (kind >= TK_INVALID || state == ST_FINISHED)
            begin
                state = ST_ERROR;
                return;
            end
            if (state == ST_VALUE || state == ST_COMMA)
            begin
                if (open_count == 0)
                begin
                    state = ST_ERROR;
                    return;
                end
                top_obj = obj_stack[open_count-1];
            end
            case (state)
                ST_START:    take_value(kind, ST_FINISHED);
                ST_OBJ_OPEN:
                begin
                    if (kind == TK_RBRACE)
                        close_box();
                    else
                        state = (kind == TK_STRING) ? ST_KEY : ST_ERROR;
                end
                ST_KEY:      state = (kind == TK_COLON) ? ST_COLON : ST_ERROR;
                ST_COLON:    take_value(kind, ST_VALUE);
                ST_VALUE:
                begin
                    if (kind == TK_COMMA)
                        state = ST_COMMA;
                    else if ((top_obj && kind == TK_RBRACE) || (!top_obj && kind == TK_RBRACKET))
                        close_box();
                    else
                        state = ST_ERROR;
                end
                ST_ARR_OPEN:
                begin
                    if (kind == TK_RBRACKET)
                        close_box();
                    else
                        take_value(kind, ST_VALUE);
                end
                ST_COMMA:
                begin
                    if (top_obj)
                        state = (kind == TK_STRING) ? ST_KEY : ST_ERROR;
                    else
                        take_value(kind, ST_VALUE);
                end
                default:     state = ST_ERROR;
            endcase
        endfunction

        function void take_token(logic [TOKEN_W-1:0] kind, logic doc_start);
            result_t want;
            if (doc_start)
            begin
                state      = ST_START;
                open_count = 0;
            end
            advance(kind);
            case (state)
                ST_FINISHED: want.verdict = VERDICT_COMPLETE;
                ST_ERROR:    want.verdict = VERDICT_ERROR;
                ST_DEEP:     want.verdict = VERDICT_TOO_DEEP;
                default:     want.verdict = VERDICT_INCOMPLETE;
            endcase
            want.nesting_depth = open_count[DEPTH_W-1:0];
            if (open_count > deepest)
                deepest = open_count;
            pending_verdicts = {pending_verdicts, want};
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        function void check_verdict(logic [VERDICT_W-1:0] verdict, logic [DEPTH_W-1:0] depth);
            result_t want;
            if (pending_verdicts.size() == 0)
            begin
                flag($sformatf("result with nothing owed: verdict %0d depth %0d", verdict, depth));
                return;
            end
            want = pending_verdicts.pop_front();
            checked++;
            verdict_hits[want.verdict]++;
            if (verdict !== want.verdict || depth !== want.nesting_depth)
                flag($sformatf("result %0d: verdict %0d depth %0d, expected verdict %0d depth %0d",
                               checked, verdict, depth, want.verdict, want.nesting_depth));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    jtsc_token_if  tok_ch ();
    jtsc_result_if res_ch ();
    jtsc_cfg_if    cfg_ch ();

    json_token_syntax_checker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    verdict_tracker board;
    bit             calm;
    bit             fresh_doc;
    int             doc_goal;
    int             tokens_sent;
    int             directed_count;
    int             settings_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_span();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    // Target depth for the next document: mostly shallow, now and then right at the limit
    function automatic int next_goal();
        int r;
        int cap;
        r   = $urandom_range(99);
        cap = board.depth_cap();
        if (r < 60)
            return $urandom_range(3);
        if (r < 95)
            return $urandom_range(12, 4);
        return (cap > 0) ? cap - 1 + $urandom_range(2) : $urandom_range(1);
    endfunction

    function automatic logic [TOKEN_W-1:0] pick_value(bit deeper);
        if (deeper && $urandom_range(9) < 8)
            return ($urandom_range(3) == 0) ? TK_LBRACE : TK_LBRACKET;
        return TOKEN_W'($urandom_range(int'(TK_NULL), int'(TK_STRING)));
    endfunction

    // Mostly grammatical tokens steered toward doc_goal, with some noise and broken docs
    task automatic pick_token(output logic [TOKEN_W-1:0] kind, output logic doc_start);
        parse_state_t st;
        int           cnt;
        int           noise;
        bit           deeper;
        bit           top_obj;
        doc_start = 1'b0;
        if (fresh_doc)
        begin
            doc_start = 1'b1;
            fresh_doc = 1'b0;
        end
        else if (board.state inside {ST_FINISHED, ST_ERROR, ST_DEEP})
        begin
            if ($urandom_range(99) < 80)
            begin
                doc_start = 1'b1;
                doc_goal  = next_goal();
            end
        end
        else if (doc_goal < 16 && $urandom_range(99) < 2)
        begin
            doc_start = 1'b1;
            doc_goal  = next_goal();
        end
        st      = doc_start ? ST_START : board.state;
        cnt     = doc_start ? 0 : board.open_count;
        noise   = (doc_goal < 16) ? 6 : 0;
        deeper  = cnt < doc_goal;
        top_obj = (cnt > 0) ? board.obj_stack[cnt-1] : 1'b0;
        if ($urandom_range(99) < noise)
            kind = TOKEN_W'($urandom_range(15));
        else
        begin
            case (st)
                ST_START, ST_COLON: kind = pick_value(deeper);
                ST_OBJ_OPEN:
                    kind = (deeper || $urandom_range(1) == 0) ? TK_STRING : TK_RBRACE;
                ST_KEY:             kind = TK_COLON;
                ST_ARR_OPEN:
                    kind = (!deeper && $urandom_range(2) == 0) ? TK_RBRACKET : pick_value(deeper);
                ST_VALUE:
                begin
                    if ((deeper && $urandom_range(3) != 0) || $urandom_range(3) == 0)
                        kind = TK_COMMA;
                    else
                        kind = top_obj ? TK_RBRACE : TK_RBRACKET;
                end
                ST_COMMA:           kind = top_obj ? TK_STRING : pick_value(deeper);
                default:            kind = TOKEN_W'($urandom_range(15));
            endcase
        end
    endtask

    // Call at a rising edge; returns at the edge the request was taken (or after its gap)
    task automatic send_token(input logic [TOKEN_W-1:0] kind, input logic doc_start);
        int gap;
        tok_ch.valid          <= 1'b1;
        tok_ch.token_kind     <= kind;
        tok_ch.document_start <= doc_start;
        do
            @(posedge clk);
        while (!tok_ch.ready);
        board.take_token(kind, doc_start);
        tokens_sent++;
        if ($urandom_range(59) == 0)
            calm = !calm;
        gap = idle_span();
        if (gap > 0)
        begin
            tok_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        board.limit = value;
        settings_used++;
    endtask

    // Result side: random backpressure, check every taken result
    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                board.check_verdict(res_ch.verdict, res_ch.nesting_depth);
            if (stall == 0 && $urandom_range(3) == 0)
                stall = idle_span();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Ends the run if no request or result moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        logic [4:0]         script[$];
        logic [LIMIT_W-1:0] limit_plan[NUM_PHASES];
        logic [TOKEN_W-1:0] kind;
        logic               doc_start;

        board          = new();
        calm           = 1'b0;
        fresh_doc      = 1'b0;
        doc_goal       = 0;
        tokens_sent    = 0;
        settings_used  = 0;
        rst_n                 <= 1'b0;
        tok_ch.valid          <= 1'b0;
        tok_ch.token_kind     <= TK_LBRACE;
        tok_ch.document_start <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.data           <= LIMIT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty object, empty array, a nested object, token after finish,
        // trailing comma, spare kinds
        script = '{
            {1'b1, TK_LBRACE},   {1'b0, TK_RBRACE},
            {1'b1, TK_LBRACKET}, {1'b0, TK_RBRACKET},
            {1'b1, TK_LBRACE},   {1'b0, TK_STRING},   {1'b0, TK_COLON},    {1'b0, TK_INT},
            {1'b0, TK_COMMA},    {1'b0, TK_STRING},   {1'b0, TK_COLON},    {1'b0, TK_LBRACKET},
            {1'b0, TK_FLOAT},    {1'b0, TK_COMMA},    {1'b0, TK_TRUE},     {1'b0, TK_RBRACKET},
            {1'b0, TK_RBRACE},
            {1'b1, TK_SCI},      {1'b0, TK_FALSE},
            {1'b1, TK_LBRACKET}, {1'b0, TK_NULL},     {1'b0, TK_COMMA},    {1'b0, TK_RBRACKET},
            {1'b1, TK_INVALID},  {1'b1, TK_RSVD0},    {1'b1, TK_RSVD1}
        };
        foreach (script[i])
            send_token(script[i][3:0], script[i][4]);
        tok_ch.valid <= 1'b0;
        directed_count = tokens_sent;

        limit_plan[0] = 7'd1;
        limit_plan[1] = 7'd0;
        limit_plan[2] = 7'd127;
        limit_plan[3] = LIMIT_W'($urandom_range(63, 2));
        limit_plan[4] = LIMIT_RESET;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(limit_plan[p]);
            // first document of each setting pushes one level past the limit
            doc_goal  = board.depth_cap() + 1;
            fresh_doc = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                pick_token(kind, doc_start);
                send_token(kind, doc_start);
            end
            tok_ch.valid <= 1'b0;
        end

        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        $display("Ran %0d token requests (%0d directed) across %0d nesting limits, %0d checked,",
                 tokens_sent, directed_count, settings_used, board.checked);
        $display("  verdicts incomplete/complete/error/too-deep %0d/%0d/%0d/%0d, max depth %0d, %0d bad",
                 board.verdict_hits[0], board.verdict_hits[1], board.verdict_hits[2],
                 board.verdict_hits[3], board.deepest, board.mismatches);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
